>>> design/adm_pkg.sv
package adm_pkg;

    localparam int WINDOW_LENGTH = 100;
    localparam int SAMPLE_W      = 16;
    localparam int AMP_W         = 15;
    localparam int STEP_W        = 15;
    localparam int BYTE_W        = 8;
    localparam int POS_W         = 3;
    localparam int COUNT_W       = 4;
    localparam int M_DATA_W      = 16;

    localparam logic [STEP_W-1:0] STEP_RESET = 15'd839;

    localparam int SUM_W  = $clog2(WINDOW_LENGTH * (2 ** AMP_W - 1) + 1);
    localparam int SEEN_W = $clog2(WINDOW_LENGTH + 1);

    // floor(sum / WINDOW_LENGTH) as (sum * RECIP) >> RECIP_SHIFT
    localparam int RECIP_SHIFT = SUM_W + $clog2(WINDOW_LENGTH);
    localparam longint unsigned RECIP =
        ((64'd1 << RECIP_SHIFT) + WINDOW_LENGTH - 1) / WINDOW_LENGTH;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PROD_W  = SUM_W + RECIP_W;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
        logic                       full;
        logic [AMP_W-1:0]           mean;
    } adm_item_t;

endpackage

>>> design/adaptive_delta_modulation_encoder_top.sv
// one-bit adaptive delta-modulation encoder
// s_* channel: one signed q1.15 audio sample per word, s_tlast ends the stream
// m_* channel: one packed byte per word, first coded bit in bit 0
// cfg_we / cfg_wdata: step size, written while the block is idle
// each sample gives one coded bit; a word leaves when eight bits are
// collected or when the stream ends, and the last word carries m_tlast
// throughput: one sample per cycle, sustained while m_* accepts its words
// a byte's final sample reaches m_* through the window sum register, the mean
// multiply register and the tracking loop with its output register
// the decision threshold adds the mean amplitude of the last 100 samples
// once 100 samples are in; the window is a shift line of amplitude cells
// reset clears the stream state and loads step size 839, no clearing pass
// after the last sample all stream state returns to reset, step size stays
// a stalled m_* side holds its word; samples keep flowing until a second
// byte is ready, then s_tready drops
module adaptive_delta_modulation_encoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // sample
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // packed_bits, bit_count, zero pad
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [14:0] cfg_wdata
);
    import adm_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic              item_valid;
    logic              item_ready;
    adm_item_t         item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_RESET;
        end
        else if (cfg_we)
        begin
            step_reg <= cfg_wdata;
        end
    end

    adm_window u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .sample      (s_tdata),
        .last_sample (s_tlast),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item)
    );

    adm_coder u_coder (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .step_size  (step_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

>>> design/adm_cell.sv
module adm_cell (
    input  logic                      clk,
    input  logic                      shift,
    input  logic [adm_pkg::AMP_W-1:0] d,
    output logic [adm_pkg::AMP_W-1:0] q
);
    import adm_pkg::*;

    logic [AMP_W-1:0] amp_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            amp_reg <= d;
        end
    end

    assign q = amp_reg;

endmodule

>>> design/adm_window.sv
module adm_window (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [adm_pkg::SAMPLE_W-1:0] sample,
    input  logic                                last_sample,
    output logic                                item_valid,
    input  logic                                item_ready,
    output adm_pkg::adm_item_t                  item
);
    import adm_pkg::*;

    logic [AMP_W-1:0]           tap [WINDOW_LENGTH];
    logic [AMP_W-1:0]           amp;
    logic [SAMPLE_W-1:0]        neg;
    logic                       full;
    logic                       take;
    logic                       en1;
    logic                       en2;
    logic [SUM_W-1:0]           sum_new;
    logic [PROD_W-1:0]          prod;

    logic [SUM_W-1:0]           sum_reg;
    logic [SEEN_W-1:0]          seen_reg;
    logic                       v1_reg;
    logic signed [SAMPLE_W-1:0] s1_sample_reg;
    logic                       s1_last_reg;
    logic                       s1_full_reg;
    logic [SUM_W-1:0]           s1_sum_reg;
    logic                       v2_reg;
    adm_item_t                  item_reg;

    // absolute amplitude, most negative sample saturates
    always_comb
    begin
        neg = SAMPLE_W'(0) - SAMPLE_W'(sample);
        if (!sample[SAMPLE_W-1])
        begin
            amp = sample[AMP_W-1:0];
        end
        else if (neg[SAMPLE_W-1])
        begin
            amp = {AMP_W{1'b1}};
        end
        else
        begin
            amp = neg[AMP_W-1:0];
        end
    end

    // amplitude delay line, oldest word at the far end
    for (genvar g = 0; g < WINDOW_LENGTH; g++)
    begin : g_cell
        if (g == 0)
        begin : g_head
            adm_cell u_cell (
                .clk   (clk),
                .shift (take),
                .d     (amp),
                .q     (tap[g])
            );
        end
        else
        begin : g_body
            adm_cell u_cell (
                .clk   (clk),
                .shift (take),
                .d     (tap[g-1]),
                .q     (tap[g])
            );
        end
    end

    assign full    = (seen_reg == SEEN_W'(WINDOW_LENGTH));
    assign sum_new = sum_reg + SUM_W'(amp) - (full ? SUM_W'(tap[WINDOW_LENGTH-1]) : '0);

    assign en2      = !v2_reg || item_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;
    assign take     = in_valid && en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            seen_reg <= '0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                if (last_sample)
                begin
                    sum_reg  <= '0;
                    seen_reg <= '0;
                end
                else
                begin
                    sum_reg <= sum_new;
                    if (!full)
                    begin
                        seen_reg <= seen_reg + SEEN_W'(1);
                    end
                end
            end
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    assign prod = PROD_W'(s1_sum_reg) * PROD_W'(RECIP);

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_sample_reg <= sample;
            s1_last_reg   <= last_sample;
            s1_full_reg   <= full;
            s1_sum_reg    <= sum_new;
        end
        if (en2 && v1_reg)
        begin
            item_reg.sample <= s1_sample_reg;
            item_reg.last   <= s1_last_reg;
            item_reg.full   <= s1_full_reg;
            item_reg.mean   <= prod[RECIP_SHIFT +: AMP_W];
        end
    end

    assign item_valid = v2_reg;
    assign item       = item_reg;

endmodule

>>> design/adm_coder.sv
module adm_coder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  adm_pkg::adm_item_t                  item,
    input  logic [adm_pkg::STEP_W-1:0]          step_size,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [adm_pkg::M_DATA_W-1:0]        m_tdata,
    output logic                                m_tlast
);
    import adm_pkg::*;

    logic signed [SAMPLE_W-1:0] tv_reg;
    logic                       alt_reg;
    logic [BYTE_W-1:0]          buf_reg;
    logic [POS_W-1:0]           pos_reg;
    logic                       m_valid_reg;
    logic [BYTE_W-1:0]          m_bits_reg;
    logic [COUNT_W-1:0]         m_count_reg;
    logic                       m_last_reg;

    logic [SAMPLE_W:0]          thr;
    logic signed [SAMPLE_W:0]   dlt;
    logic [SAMPLE_W:0]          mag;
    logic                       b;
    logic signed [SAMPLE_W+1:0] tsum;
    logic signed [SAMPLE_W+1:0] step_ext;
    logic signed [SAMPLE_W-1:0] tv_sat;
    logic [BYTE_W-1:0]          buf_new;
    logic                       emit;
    logic                       take;

    always_comb
    begin
        thr = (SAMPLE_W + 1)'(step_size) + (item.full ? (SAMPLE_W + 1)'(item.mean) : '0);
        dlt = (SAMPLE_W + 1)'(item.sample) - (SAMPLE_W + 1)'(tv_reg);
        mag = dlt[SAMPLE_W] ? (SAMPLE_W + 1)'(-dlt) : (SAMPLE_W + 1)'(dlt);
        // inside the threshold the bits alternate
        b = (mag < thr) ? alt_reg : !dlt[SAMPLE_W];
        step_ext = signed'((SAMPLE_W + 2)'(step_size));
        tsum = b ? (SAMPLE_W + 2)'(tv_reg) + step_ext : (SAMPLE_W + 2)'(tv_reg) - step_ext;
        if (tsum > signed'((SAMPLE_W + 2)'(32767)))
        begin
            tv_sat = 16'sh7fff;
        end
        else if (tsum < -signed'((SAMPLE_W + 2)'(32768)))
        begin
            tv_sat = 16'sh8000;
        end
        else
        begin
            tv_sat = tsum[SAMPLE_W-1:0];
        end
        buf_new = buf_reg | (BYTE_W'(b) << pos_reg);
        emit    = (pos_reg == {POS_W{1'b1}}) || item.last;
    end

    assign item_ready = !(emit && m_valid_reg && !m_tready);
    assign take       = item_valid && item_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tv_reg      <= '0;
            alt_reg     <= 1'b0;
            buf_reg     <= '0;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                tv_reg  <= item.last ? '0 : tv_sat;
                alt_reg <= item.last ? 1'b0 : !b;
                buf_reg <= emit ? '0 : buf_new;
                pos_reg <= emit ? '0 : pos_reg + POS_W'(1);
            end
            if (take && emit)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            m_bits_reg  <= buf_new;
            m_count_reg <= COUNT_W'(pos_reg) + COUNT_W'(1);
            m_last_reg  <= item.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_DATA_W - BYTE_W - COUNT_W)'(0), m_count_reg, m_bits_reg};
    assign m_tlast  = m_last_reg;

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        take && item.last |=> pos_reg == '0 && tv_reg == '0 && buf_reg == '0)
        else $error("stream state not cleared after last word");

    a_full_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && !m_last_reg |-> m_count_reg == COUNT_W'(8))
        else $error("partial byte without last flag");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> m_count_reg != '0 && m_count_reg <= COUNT_W'(8))
        else $error("bit count out of range");

    a_track_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(tv_reg) && $stable(pos_reg))
        else $error("coder state moved without a word");

endmodule
